// File: rtl/ipv4p_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types and codes for the IPv4 dotted-decimal text parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

  // Character classes as sorted by the front end
  typedef enum logic [2:0] {
    CC_SPACE,
    CC_DIGIT,
    CC_HEX,
    CC_DOT,
    CC_SLASH,
    CC_COLON,
    CC_OTHER,
    CC_END
  } char_class_e;

  // Result status codes
  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_COLON   = 2'd2;

  // Octet range and suffix length
  localparam int unsigned OctetLimit  = 256;
  localparam int unsigned PrefixLen   = 32;
  localparam int unsigned MaxSigDigit = 4;
  localparam int unsigned LastGroup   = 3;

  // One classified beat in the queue
  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
  } item_t;

endpackage : ipv4p_pkg
`default_nettype wire

// File: rtl/ipv4p_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4p_front
// Input handshake and character classification; pushes one classified beat
// into the queue per accepted input beat.
// ----------------------------------------------------------------------------
module ipv4p_front (
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      char_code_i,
  input  wire logic            end_mark_i,
  input  wire logic            q_full_i,
  output logic                 in_stall_o,
  output logic                 push_o,
  output ipv4p_pkg::item_t     item_o
);

  logic is_space, is_digit, is_hex;

  assign is_space = (char_code_i == 8'd32) ||
                    ((char_code_i >= 8'd9) && (char_code_i <= 8'd13));
  assign is_digit = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);
  assign is_hex   = ((char_code_i >= 8'h61) && (char_code_i <= 8'h66)) ||
                    ((char_code_i >= 8'h41) && (char_code_i <= 8'h46));

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.digit = char_code_i[3:0];
    priority if (end_mark_i)            item_o.cls = ipv4p_pkg::CC_END;
    else if (char_code_i == 8'h3A)      item_o.cls = ipv4p_pkg::CC_COLON;
    else if (is_space)                  item_o.cls = ipv4p_pkg::CC_SPACE;
    else if (is_digit)                  item_o.cls = ipv4p_pkg::CC_DIGIT;
    else if (is_hex)                    item_o.cls = ipv4p_pkg::CC_HEX;
    else if (char_code_i == 8'h2E)      item_o.cls = ipv4p_pkg::CC_DOT;
    else if (char_code_i == 8'h2F)      item_o.cls = ipv4p_pkg::CC_SLASH;
    else                                item_o.cls = ipv4p_pkg::CC_OTHER;
  end

endmodule : ipv4p_front
`default_nettype wire

// File: rtl/ipv4p_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4p_fifo
// Short queue of classified beats between front end and parser.
// ----------------------------------------------------------------------------
module ipv4p_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ipv4p_pkg::item_t item_i,
  input  wire logic             pop_i,
  output ipv4p_pkg::item_t      item_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  ipv4p_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == FullCnt);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntOne;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntOne;
      end
    end
  end

endmodule : ipv4p_fifo
`default_nettype wire

// File: rtl/ipv4p_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4p_back
// Parser state machine: takes classified beats from the queue, tracks groups
// and suffix, and loads the result register on the end marker.
// ----------------------------------------------------------------------------
module ipv4p_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ipv4p_pkg::item_t item_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [1:0]            status_o,
  output logic [31:0]           address_o,
  output logic                  had_prefix_o
);

  typedef enum logic [1:0] {
    M_LEAD,
    M_FIRST,
    M_LATER,
    M_SUFFIX
  } mode_e;

  mode_e        mode_q, mode_d, eff_mode;
  logic         trail_q, trail_d;
  logic [1:0]   gcount_q, gcount_d;
  logic [31:0]  store_q, store_d;
  logic [13:0]  value_q, value_d;
  logic         nonempty_q, nonempty_d;
  logic [2:0]   sig_q, sig_d;
  logic         hex_q, hex_d;
  logic [1:0]   sticky_q, sticky_d;
  logic         out_valid_q, out_valid_d;
  logic [1:0]   status_q, status_d;
  logic [31:0]  addr_q, addr_d;
  logic         pref_q, pref_d;

  logic         out_free, is_end;
  logic         fin_bad;
  logic [7:0]   fin_val;
  logic [2:0]   sig_inc;
  logic         hex_new;

  assign is_end   = (item_i.cls == ipv4p_pkg::CC_END);
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = !empty_i && (!is_end || out_free);

  // Current group checked as an address byte
  assign fin_bad = !nonempty_q ||
                   ((sig_q != '0) && (hex_q || (sig_q > 3'(ipv4p_pkg::MaxSigDigit)) ||
                    (value_q >= 14'(ipv4p_pkg::OctetLimit))));
  assign fin_val = (sig_q == '0) ? 8'd0 : value_q[7:0];

  assign hex_new = hex_q || (item_i.cls == ipv4p_pkg::CC_HEX);
  // significant digits counted from the first non-zero char, saturating at 5
  assign sig_inc = ((sig_q != '0) || (item_i.cls == ipv4p_pkg::CC_HEX) ||
                    (item_i.digit != 4'd0)) && (sig_q < 3'd5) ? sig_q + 3'd1 : sig_q;

  always_comb begin
    mode_d      = mode_q;
    trail_d     = trail_q;
    gcount_d    = gcount_q;
    store_d     = store_q;
    value_d     = value_q;
    nonempty_d  = nonempty_q;
    sig_d       = sig_q;
    hex_d       = hex_q;
    sticky_d    = sticky_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    addr_d      = addr_q;
    pref_d      = pref_q;
    eff_mode    = (mode_q == M_LEAD) ? M_FIRST : mode_q;

    if (pop_o) begin
      if (is_end) begin
        out_valid_d = 1'b1;
        addr_d      = '0;
        pref_d      = 1'b0;
        status_d    = sticky_q;
        if (sticky_q == ipv4p_pkg::ST_VALID) begin
          status_d = ipv4p_pkg::ST_INVALID;
          if ((mode_q == M_LATER) && (gcount_q == 2'(ipv4p_pkg::LastGroup))) begin
            if (!fin_bad) begin
              status_d = ipv4p_pkg::ST_VALID;
              addr_d   = {store_q[23:0], fin_val};
            end
          end else if (mode_q == M_SUFFIX) begin
            if (nonempty_q && (sig_q != '0) && (sig_q <= 3'(ipv4p_pkg::MaxSigDigit)) &&
                (value_q == 14'(ipv4p_pkg::PrefixLen))) begin
              status_d = ipv4p_pkg::ST_VALID;
              addr_d   = store_q;
              pref_d   = 1'b1;
            end
          end
        end
        mode_d     = M_LEAD;
        trail_d    = 1'b0;
        gcount_d   = '0;
        store_d    = '0;
        value_d    = '0;
        nonempty_d = 1'b0;
        sig_d      = '0;
        hex_d      = 1'b0;
        sticky_d   = ipv4p_pkg::ST_VALID;
      end else if (item_i.cls == ipv4p_pkg::CC_COLON) begin
        sticky_d = ipv4p_pkg::ST_COLON;
      end else if (sticky_q == ipv4p_pkg::ST_VALID) begin
        if (!((mode_q == M_LEAD) && (item_i.cls == ipv4p_pkg::CC_SPACE))) begin
          mode_d = eff_mode;
          if (trail_q) begin
            if (item_i.cls != ipv4p_pkg::CC_SPACE) sticky_d = ipv4p_pkg::ST_INVALID;
          end else begin
            unique case (item_i.cls)
              ipv4p_pkg::CC_SPACE: trail_d = 1'b1;
              ipv4p_pkg::CC_DOT: begin
                if ((eff_mode == M_SUFFIX) ||
                    ((eff_mode == M_LATER) && (gcount_q == 2'(ipv4p_pkg::LastGroup))) ||
                    fin_bad) begin
                  sticky_d = ipv4p_pkg::ST_INVALID;
                end else begin
                  store_d    = {store_q[23:0], fin_val};
                  gcount_d   = gcount_q + 2'd1;
                  mode_d     = M_LATER;
                  value_d    = '0;
                  nonempty_d = 1'b0;
                  sig_d      = '0;
                  hex_d      = 1'b0;
                end
              end
              ipv4p_pkg::CC_SLASH: begin
                if ((eff_mode != M_LATER) || (gcount_q != 2'(ipv4p_pkg::LastGroup)) ||
                    fin_bad) begin
                  sticky_d = ipv4p_pkg::ST_INVALID;
                end else begin
                  store_d    = {store_q[23:0], fin_val};
                  mode_d     = M_SUFFIX;
                  value_d    = '0;
                  nonempty_d = 1'b0;
                  sig_d      = '0;
                  hex_d      = 1'b0;
                end
              end
              ipv4p_pkg::CC_DIGIT, ipv4p_pkg::CC_HEX: begin
                nonempty_d = 1'b1;
                hex_d      = hex_new;
                sig_d      = sig_inc;
                if ((item_i.cls == ipv4p_pkg::CC_DIGIT) && !hex_new &&
                    (sig_inc <= 3'(ipv4p_pkg::MaxSigDigit))) begin
                  value_d = 14'(value_q * 14'd10) + {10'd0, item_i.digit};
                end
              end
              default: sticky_d = ipv4p_pkg::ST_INVALID;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= M_LEAD;
      trail_q     <= 1'b0;
      gcount_q    <= '0;
      store_q     <= '0;
      value_q     <= '0;
      nonempty_q  <= 1'b0;
      sig_q       <= '0;
      hex_q       <= 1'b0;
      sticky_q    <= ipv4p_pkg::ST_VALID;
      out_valid_q <= 1'b0;
      status_q    <= ipv4p_pkg::ST_VALID;
      addr_q      <= '0;
      pref_q      <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      trail_q     <= trail_d;
      gcount_q    <= gcount_d;
      store_q     <= store_d;
      value_q     <= value_d;
      nonempty_q  <= nonempty_d;
      sig_q       <= sig_d;
      hex_q       <= hex_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      addr_q      <= addr_d;
      pref_q      <= pref_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign address_o    = addr_q;
  assign had_prefix_o = pref_q;

  // An end marker taken from the queue always loads a fresh result
  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_end) |=> out_valid_q)
    else $error("end marker popped without loading result");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_end) |=> (mode_q == M_LEAD) && !trail_q && (gcount_q == '0) &&
                          (sticky_q == ipv4p_pkg::ST_VALID))
    else $error("parser state not cleared after end marker");

  a_addr_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ipv4p_pkg::ST_VALID)) |-> ((addr_q == '0) && !pref_q))
    else $error("failed result carries address or prefix");

  a_no_pop_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && is_end) |-> !pop_o)
    else $error("end marker popped over a pending result");

endmodule : ipv4p_back
`default_nettype wire

// File: rtl/ipv4_text_address_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_text_address_parser
// IPv4 dotted-decimal text parser, one character beat per cycle when not stalled.
// Throughput: one input beat per cycle while the queue has room.
// Result path: the accepted end-marker beat is written into the queue, then
// popped into the result register, provided the result register is free.
// Stalls: a held result blocks only an end marker; input stalls once the
// queue fills behind it.
// Reset: asynchronous, active low; clears queue, parser and result valid.
// ----------------------------------------------------------------------------
module ipv4_text_address_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_mark_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      address_o,
  output logic             had_prefix_o
);

  ipv4p_pkg::item_t push_item, pop_item;
  logic             push, pop, q_empty, q_full;

  ipv4p_front u_front (
    .in_valid_i  (in_valid_i),
    .char_code_i (char_code_i),
    .end_mark_i  (end_mark_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .item_o      (push_item)
  );

  ipv4p_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  ipv4p_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (pop_item),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .address_o    (address_o),
    .had_prefix_o (had_prefix_o)
  );

endmodule : ipv4_text_address_parser
`default_nettype wire
